### hdl/dnacre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnacre_pkg
// Shared types and constants for the DNA context range encoder.
// ----------------------------------------------------------------------------
package dnacre_pkg;

  localparam int CNT_W   = 16;
  localparam int TOT_W   = 18;  // sum of four counts
  localparam int RANGE_W = 32;
  localparam int LOW_W   = 33;

  localparam logic [RANGE_W-1:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [RANGE_W-1:0] LOW_LIMIT  = 32'hFF00_0000;
  localparam logic [RANGE_W-1:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;
  localparam logic [2:0]         FLUSH_LAST = 3'd4;  // five shifts, counted from zero

  localparam logic [3:0]  ORDER_RST = 4'd8;
  localparam logic [7:0]  INC_RST   = 8'd32;
  localparam logic [15:0] LIMIT_RST = 16'd8192;

  typedef enum logic [1:0] {
    REG_ORDER = 2'd0,
    REG_INC   = 2'd1,
    REG_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### hdl/dnacre_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnacre_div
// Restoring divider, one quotient bit per cycle, 32-bit range by count total.
// ----------------------------------------------------------------------------
module dnacre_div
  import dnacre_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [RANGE_W-1:0] dividend,
  input  wire logic [TOT_W-1:0]   divisor,
  output logic [RANGE_W-1:0]      quotient,
  output div_stat_t               stat
);

  logic [TOT_W-1:0]   rem_r;
  logic [RANGE_W-1:0] quo_r;
  logic [TOT_W-1:0]   dsr_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [TOT_W:0]     shifted;
  logic [TOT_W:0]     trial;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[RANGE_W-1]};
    trial   = shifted - {1'b0, dsr_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[TOT_W]) begin
        rem_r <= trial[TOT_W-1:0];
        quo_r <= {quo_r[RANGE_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[TOT_W-1:0];
        quo_r <= {quo_r[RANGE_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

### hdl/dnacre_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnacre_ram
// Count store: one row of four counts per context, registered read.
// ----------------------------------------------------------------------------
module dnacre_ram #(
  parameter int AW = 16,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/dna_context_range_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dna_context_range_encoder_unit
// Order-k context model feeding an LZMA-style range coder, one base per item.
// ----------------------------------------------------------------------------
// After reset the count store is swept to its initial counts, one row a cycle,
// over all 4**MAX_ORDER rows (65536 at the default); no item is taken
// meanwhile, though configuration writes are. One item is worked at a time.
// An encode item runs from its transfer through a store read and latch, the
// bit-serial divider (32 steps), the shared multiplier and adder, a range
// check, any renormalising shifts (at most three), the count write-back and a
// closing step. A flush runs five shifts and the closing step. Output stall
// can hold the shifts and the closing step.
module dna_context_range_encoder_unit
  import dnacre_pkg::*;
#(
  parameter int MAX_ORDER = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [1:0]  in_base,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_value,
  output logic [31:0]      out_repeat_count,
  output logic             out_run_overflow,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW = 2 * MAX_ORDER;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LATCH, S_DIV, S_MUL1, S_ADDLO, S_MUL2,
    S_SETRG, S_RENORM, S_SHA, S_SHB, S_UPDATE, S_END
  } state_t;

  state_t state_r;

  // configuration
  logic [3:0]  order_r;
  logic [7:0]  inc_r;
  logic [15:0] limit_r;

  // coder state
  logic [LOW_W-1:0]   low_r;
  logic [RANGE_W-1:0] range_r;
  logic [7:0]         cached_r;
  logic [31:0]        pending_r;
  logic               run_sat_r;
  logic [AW-1:0]      hist_r;

  // per-item working registers
  logic [AW-1:0]      ctx_r;
  logic [AW-1:0]      clr_r;
  logic [1:0]         base_r;
  logic               flush_r;
  logic [2:0]         sh_cnt_r;
  logic [CNT_W-1:0]   row_r [4];
  logic [TOT_W-1:0]   total_r;
  logic [TOT_W-1:0]   offset_r;
  logic [CNT_W-1:0]   cs_r;
  logic [RANGE_W-1:0] q_r;
  logic [49:0]        mul_r;

  // staged record, sent once the next one arrives or the item ends
  logic               stg_valid_r;
  logic [7:0]         stg_byte_r;
  logic [31:0]        stg_rep_r;
  logic               stg_ovf_r;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic [31:0]        out_rep_r;
  logic               out_ovf_r;
  logic               out_last_r;

  // ram and divider hookup
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [63:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [63:0]        ram_rdata;
  logic               div_start;
  logic [RANGE_W-1:0] div_quo;
  div_stat_t          div_st;

  // context selection
  logic [3:0]         order_eff;
  logic [AW-1:0]      ctx_mask;
  logic [CNT_W-1:0]   rd_cnt [4];
  logic [TOT_W-1:0]   rd_total;
  logic [TOT_W-1:0]   rd_offset;

  // shift step and count update
  logic               carry;
  logic [31:0]        low32;
  logic               sh_emit;
  logic               out_free;
  logic               can_emit;
  logic               out_load;
  logic [CNT_W:0]     grown;
  logic [CNT_W-1:0]   grown_sat;
  logic [TOT_W:0]     halve_sum;
  logic               halve;
  logic [CNT_W-1:0]   new_cnt [4];
  logic [49:0]        mul_res;
  logic [TOT_W-1:0]   mul_b;

  always_comb begin
    order_eff = (order_r > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_r;
    for (int i = 0; i < MAX_ORDER; i++) begin
      ctx_mask[2*i +: 2] = (4'(i) < order_eff) ? 2'b11 : 2'b00;
    end
  end

  // unpack the row read from the store
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rd_cnt[j] = ram_rdata[CNT_W*j +: CNT_W];
    end
    rd_total  = TOT_W'(rd_cnt[0]) + TOT_W'(rd_cnt[1])
              + TOT_W'(rd_cnt[2]) + TOT_W'(rd_cnt[3]);
    rd_offset = '0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < base_r) rd_offset = rd_offset + TOT_W'(rd_cnt[j]);
    end
  end

  // grow, saturate and maybe halve the row
  always_comb begin
    grown     = {1'b0, cs_r} + (CNT_W+1)'(inc_r);
    grown_sat = grown[CNT_W] ? CNT_MAX : grown[CNT_W-1:0];
    halve_sum = {1'b0, total_r} + (TOT_W+1)'(inc_r);
    halve     = (halve_sum >= (TOT_W+1)'(limit_r));
    for (int j = 0; j < 4; j++) begin
      new_cnt[j] = (2'(j) == base_r) ? grown_sat : row_r[j];
      if (halve) new_cnt[j] = {1'b0, new_cnt[j][CNT_W-1:1]} | CNT_W'(1);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_b   = (state_r == S_MUL1) ? offset_r : TOT_W'(cs_r);
    mul_res = 50'(q_r) * 50'(mul_b);
  end

  always_comb begin
    carry    = low_r[LOW_W-1];
    low32    = low_r[31:0];
    sh_emit  = carry || (low32 < LOW_LIMIT);
    out_free = !out_valid_r || !out_stall;
    can_emit = !stg_valid_r || out_free;
    // the staged record moves to the output register this cycle
    out_load = stg_valid_r &&
               (((state_r == S_SHA) && sh_emit && can_emit) ||
                ((state_r == S_SHB) && (pending_r > 32'd1) && can_emit) ||
                ((state_r == S_END) && out_free));
  end

  // store ports
  always_comb begin
    ram_raddr = hist_r & ctx_mask;
    ram_we    = (state_r == S_CLEAR) || (state_r == S_UPDATE);
    ram_waddr = (state_r == S_CLEAR) ? clr_r : ctx_r;
    if (state_r == S_CLEAR) begin
      ram_wdata = {4{CNT_W'(1)}};
    end else begin
      ram_wdata = {new_cnt[3], new_cnt[2], new_cnt[1], new_cnt[0]};
    end
    div_start = (state_r == S_LATCH);
  end

  dnacre_ram #(.AW(AW), .DW(64)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dnacre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (range_r),
    .divisor  (rd_total),
    .quotient (div_quo),
    .stat     (div_st)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RST;
      inc_r   <= INC_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER: order_r <= cfg_wdata[3:0];
        REG_INC:   inc_r   <= cfg_wdata[7:0];
        REG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      low_r       <= '0;
      range_r     <= ALL_ONES32;
      cached_r    <= '0;
      pending_r   <= 32'd1;
      run_sat_r   <= 1'b0;
      hist_r      <= '0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
      sh_cnt_r    <= '0;
    end else begin
      // drop a taken output
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (&clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            base_r   <= in_base;
            sh_cnt_r <= '0;
            if (in_command == CMD_FLUSH) begin
              flush_r <= 1'b1;
              state_r <= S_SHA;
            end else begin
              flush_r <= 1'b0;
              ctx_r   <= hist_r & ctx_mask;
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_LATCH;
        S_LATCH: begin
          for (int j = 0; j < 4; j++) row_r[j] <= rd_cnt[j];
          total_r  <= rd_total;
          offset_r <= rd_offset;
          cs_r     <= rd_cnt[base_r];
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            q_r     <= div_quo;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          mul_r   <= mul_res;
          state_r <= S_ADDLO;
        end
        S_ADDLO: begin
          low_r   <= low_r + mul_r[LOW_W-1:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          mul_r   <= mul_res;
          state_r <= S_SETRG;
        end
        S_SETRG: begin
          range_r <= mul_r[RANGE_W-1:0];
          state_r <= S_RENORM;
        end
        S_RENORM: begin
          if (range_r < TOP_VALUE) begin
            range_r <= {range_r[23:0], 8'h00};
            state_r <= S_SHA;
          end else begin
            state_r <= S_UPDATE;
          end
        end
        S_SHA: begin
          if (sh_emit) begin
            if (can_emit) begin
              if (stg_valid_r) begin
                out_valid_r <= 1'b1;
                out_byte_r  <= stg_byte_r;
                out_rep_r   <= stg_rep_r;
                out_ovf_r   <= stg_ovf_r;
                out_last_r  <= 1'b0;
              end
              stg_valid_r <= 1'b1;
              stg_byte_r  <= cached_r + 8'(carry);
              stg_rep_r   <= 32'd1;
              stg_ovf_r   <= 1'b0;
              state_r     <= S_SHB;
            end
          end else begin
            // no byte leaves: extend the pending run
            if (pending_r == ALL_ONES32) run_sat_r <= 1'b1;
            else pending_r <= pending_r + 32'd1;
            low_r <= {1'b0, low32[23:0], 8'h00};
            if (flush_r) begin
              sh_cnt_r <= sh_cnt_r + 3'd1;
              if (sh_cnt_r == FLUSH_LAST) state_r <= S_END;
            end else begin
              state_r <= S_RENORM;
            end
          end
        end
        S_SHB: begin
          if (pending_r <= 32'd1 || can_emit) begin
            if (pending_r > 32'd1) begin
              if (stg_valid_r) begin
                out_valid_r <= 1'b1;
                out_byte_r  <= stg_byte_r;
                out_rep_r   <= stg_rep_r;
                out_ovf_r   <= stg_ovf_r;
                out_last_r  <= 1'b0;
              end
              stg_valid_r <= 1'b1;
              stg_byte_r  <= 8'hFF + 8'(carry);
              stg_rep_r   <= pending_r - 32'd1;
              stg_ovf_r   <= run_sat_r;
            end
            cached_r  <= low32[31:24];
            pending_r <= 32'd1;
            run_sat_r <= 1'b0;
            low_r     <= {1'b0, low32[23:0], 8'h00};
            if (flush_r) begin
              sh_cnt_r <= sh_cnt_r + 3'd1;
              state_r  <= (sh_cnt_r == FLUSH_LAST) ? S_END : S_SHA;
            end else begin
              state_r <= S_RENORM;
            end
          end
        end
        S_UPDATE: begin
          hist_r  <= AW'({hist_r, base_r});
          state_r <= S_END;
        end
        S_END: begin
          if (flush_r) begin
            low_r     <= '0;
            range_r   <= ALL_ONES32;
            cached_r  <= '0;
            pending_r <= 32'd1;
            run_sat_r <= 1'b0;
            flush_r   <= 1'b0;
          end
          // release the final record of the item
          if (!stg_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= stg_byte_r;
            out_rep_r   <= stg_rep_r;
            out_ovf_r   <= stg_ovf_r;
            out_last_r  <= 1'b1;
            stg_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_byte_value   = out_byte_r;
  assign out_repeat_count = out_rep_r;
  assign out_run_overflow = out_ovf_r;
  assign out_last         = out_last_r;

  // an accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // the coder range is normalised between items
  a_range_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> range_r >= TOP_VALUE)
    else $error("range left below top value");

  // nothing is left staged once an item completes
  a_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !stg_valid_r)
    else $error("record left staged at idle");

  // the divider is only busy while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> state_r == S_DIV)
    else $error("divider running outside divide step");

endmodule
`default_nettype wire

### tb/dna_context_range_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_context_range_encoder_unit_tb
// Drives bases and flushes through the context range encoder under several
// register settings, with random gaps and output back-pressure, and checks each
// byte record against an in-bench model of counts and coder or typed expectations.
// ----------------------------------------------------------------------------
module dna_context_range_encoder_unit_tb
  import dnacre_pkg::*;
;

  typedef struct {
    logic [7:0]  byte_value;
    logic [31:0] repeat_count;
    logic        run_overflow;
    logic        last;
  } byte_rec_t;

  typedef struct {
    cmd_t       cmd;
    logic [1:0] base;
    bit         typed;     // expected records written out below
    int         n_recs;    // typed: number of records, all repeat 1
    logic [7:0] rec_byte;  // typed: value of every record
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [1:0]  in_base = 2'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte_value;
  logic [31:0] out_repeat_count;
  logic        out_run_overflow;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  // model state
  logic [63:0] ctx_counts [int];
  logic [15:0] ctx_hist;
  logic [32:0] m_low;
  logic [31:0] m_range;
  logic [7:0]  m_cache;
  logic [31:0] m_pending;
  bit          m_sat;
  logic [3:0]  m_order;
  logic [7:0]  m_inc;
  logic [15:0] m_limit;

  byte_rec_t   pending_bytes [$];
  byte_rec_t   new_bytes [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_recs_seen = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_req = 0;

  dna_context_range_encoder_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_base(in_base),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_value(out_byte_value), .out_repeat_count(out_repeat_count),
    .out_run_overflow(out_run_overflow), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Shift one byte out of the model low, with carry handling and the 0xFF run
  task automatic coder_shift();
    logic       carry;
    logic [31:0] low32;
    carry = m_low[32];
    low32 = m_low[31:0];
    if (carry || low32 < LOW_LIMIT) begin
      new_bytes = {new_bytes, byte_rec_t'{m_cache + carry, 32'd1, 1'b0, 1'b0}};
      if (m_pending > 1)
        new_bytes = {new_bytes, byte_rec_t'{8'hFF + carry, m_pending - 1, m_sat, 1'b0}};
      m_cache = low32[31:24];
      m_pending = 0;
      m_sat = 1'b0;
    end
    if (m_pending == ALL_ONES32) m_sat = 1'b1;
    else m_pending++;
    m_low = {1'b0, low32[23:0], 8'h00};
  endtask

  task automatic coder_clear();
    m_low = '0;
    m_range = ALL_ONES32;
    m_cache = '0;
    m_pending = 1;
    m_sat = 1'b0;
  endtask

  // Work out the byte records that one accepted item causes
  task automatic encode_item(input cmd_t c, input logic [1:0] b);
    int unsigned order, idx, total, offset, grown;
    logic [15:0] cnt [4];
    logic [63:0] row;
    logic [63:0] sum;
    new_bytes.delete();
    if (c == CMD_ENCODE) begin
      order = (m_order > 8) ? 8 : m_order;
      idx = ctx_hist & ((32'd1 << (2 * order)) - 1);
      row = ctx_counts.exists(idx) ? ctx_counts[idx] : 64'h0001_0001_0001_0001;
      for (int j = 0; j < 4; j++) cnt[j] = row[16*j +: 16];
      total = cnt[0] + cnt[1] + cnt[2] + cnt[3];
      offset = 0;
      for (int j = 0; j < b; j++) offset += cnt[j];
      m_range = m_range / total;
      sum = {31'd0, m_low} + 64'(offset) * 64'(m_range);
      m_low = sum[32:0];
      m_range = m_range * cnt[b];
      while (m_range < TOP_VALUE) begin
        m_range = m_range << 8;
        coder_shift();
      end
      grown = cnt[b] + m_inc;
      cnt[b] = (grown > 32'hFFFF) ? CNT_MAX : grown[15:0];
      if (total + m_inc >= m_limit)
        for (int j = 0; j < 4; j++) cnt[j] = (cnt[j] >> 1) | 16'd1;
      for (int j = 0; j < 4; j++) row[16*j +: 16] = cnt[j];
      ctx_counts[idx] = row;
      ctx_hist = {ctx_hist[13:0], b};
    end else begin
      repeat (5) coder_shift();
      coder_clear();
    end
    if (new_bytes.size() > 0) new_bytes[$].last = 1'b1;
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      REG_ORDER: m_order = v[3:0];
      REG_INC:   m_inc = v[7:0];
      default:   m_limit = v;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one item and hold it until transferred; optionally idle first
  task automatic send_item(input stim_row_t s);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= s.cmd;
    in_base <= s.base;
    do @(posedge clk); while (in_stall);
    n_items++;
    encode_item(s.cmd, s.base);
    if (s.typed)
      for (int k = 0; k < s.n_recs; k++)
        pending_bytes = {pending_bytes,
                         byte_rec_t'{s.rec_byte, 32'd1, 1'b0, k == s.n_recs - 1}};
    else
      foreach (new_bytes[k]) pending_bytes = {pending_bytes, new_bytes[k]};
    @(negedge clk);
  endtask

  // Wait for all records, then let the block finish any silent item
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_phase(input int n_rand);
    stim_row_t s;
    logic [1:0] fav;
    fav = $urandom_range(0, 3);
    for (int i = 0; i < n_rand; i++) begin
      s.cmd = ($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_ENCODE;
      // skew towards one base now and then for long runs and halving
      s.base = ($urandom_range(0, 1) == 0) ? fav : 2'($urandom_range(0, 3));
      s.typed = 1'b0;
      send_item(s);
    end
  endtask

  // Receiver back-pressure: random bursts, plus a long hold on request
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        burst = hold_req;
        hold_req = 0;
      end else if (burst == 0 && stalls_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each transferred record with the oldest expectation
  always @(posedge clk) begin
    byte_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_recs_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected record byte=%h repeat=%0d ovf=%b last=%b", $time,
                 out_byte_value, out_repeat_count, out_run_overflow, out_last);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte_value !== e.byte_value) begin
          $display("%0t: byte_value exp %h got %h", $time, e.byte_value, out_byte_value);
          errors++;
        end
        if (out_repeat_count !== e.repeat_count) begin
          $display("%0t: repeat_count exp %0d got %0d", $time, e.repeat_count,
                   out_repeat_count);
          errors++;
        end
        if (out_run_overflow !== e.run_overflow) begin
          $display("%0t: run_overflow exp %b got %b", $time, e.run_overflow,
                   out_run_overflow);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last exp %b got %b", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    ctx_hist = '0;
    coder_clear();
    m_order = ORDER_RST;
    m_inc = INC_RST;
    m_limit = LIMIT_RST;

    // flush straight after reset: five zero bytes; first base emits nothing
    dir_rows = {dir_rows, stim_row_t'{CMD_FLUSH,  2'd0, 1'b1, 5, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'd0, 1'b1, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'd3, 1'b0, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'd1, 1'b0, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'd2, 1'b0, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_FLUSH,  2'd3, 1'b0, 0, 8'h00}};
    for (int i = 0; i < 8; i++)
      dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'd3, 1'b0, 0, 8'h00}};
    for (int i = 0; i < 4; i++)
      dir_rows = {dir_rows, stim_row_t'{CMD_ENCODE, 2'(i), 1'b0, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_FLUSH,  2'd0, 1'b0, 0, 8'h00}};
    dir_rows = {dir_rows, stim_row_t'{CMD_FLUSH,  2'd2, 1'b0, 0, 8'h00}};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // tiny limit, big increment, one-base context: halving on every base
    cfg_write(REG_ORDER, 16'd1);
    cfg_write(REG_INC, 16'd255);
    cfg_write(REG_LIMIT, 16'd16);
    random_phase(25);
    drain();

    // long receiver hold while items keep coming, so the input backs up
    cfg_write(REG_ORDER, 16'd0);
    cfg_write(REG_INC, 16'd1);
    cfg_write(REG_LIMIT, 16'hFFFF);
    hold_req = 400;
    random_phase(25);
    drain();

    // out-of-range order and a zero limit
    cfg_write(REG_ORDER, 16'hFFFF);
    cfg_write(REG_INC, 16'd128);
    cfg_write(REG_LIMIT, 16'd0);
    random_phase(25);
    drain();

    cfg_write(REG_ORDER, 16'd4);
    cfg_write(REG_INC, 16'd200);
    cfg_write(REG_LIMIT, 16'd32768);
    random_phase(25);
    drain();

    cfg_write(REG_ORDER, 16'd8);
    cfg_write(REG_INC, 16'd32);
    cfg_write(REG_LIMIT, 16'd300);
    random_phase(25);

    // closing stretch with no idling on either side
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    random_phase(25);
    send_item('{CMD_FLUSH, 2'd1, 1'b0, 0, 8'h00});
    drain();

    $display("Run covered %0d items over six register settings, %0d byte records seen.",
             n_items, n_recs_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
